// File: rtl/core/vector_rotate_and_polar_macros.svh
// ----------------------------------------------------------------------------
// Vector rotate and polar: assertion macros
// Shared property wrappers, sampled on clock and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef VECTOR_ROTATE_AND_POLAR_MACROS_SVH
`define VECTOR_ROTATE_AND_POLAR_MACROS_SVH

// Flags any cycle on which the condition holds.
`define VRP_ASSERT_NEVER(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) !(cond)) \
      else $error(msg);

// Checks that the consequent holds on every cycle the antecedent holds.
`define VRP_ASSERT_IMPLY(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

`endif

// File: rtl/core/vrp_pkg.sv
// ----------------------------------------------------------------------------
// Vector rotate and polar: package
// Widths, beat types and the arctangent table of the CORDIC datapath.
// ----------------------------------------------------------------------------
package vrp_pkg;

   localparam int COORD_WIDTH   = 16;
   localparam int CORDIC_STAGES = 16;
   localparam int ANGLE_WIDTH   = 16;
   localparam int GUARD         = 6;
   localparam int TABLE_LEN     = 24;
   localparam int STAGES        = (CORDIC_STAGES < TABLE_LEN) ? CORDIC_STAGES : TABLE_LEN;
   localparam int DATA_WIDTH    = COORD_WIDTH + GUARD + 3;
   localparam int GAIN_WIDTH    = 24;
   localparam int GAIN_SHIFT    = GAIN_WIDTH + GUARD;
   localparam int PROD_WIDTH    = DATA_WIDTH + GAIN_WIDTH;
   localparam int ROUND_WIDTH   = PROD_WIDTH + 1 - GAIN_SHIFT;
   localparam int LATENCY       = 2 * STAGES + 8;

   localparam logic [GAIN_WIDTH-1:0] INV_GAIN   = 24'd10188014;
   localparam logic [PROD_WIDTH:0]   ROUND_HALF = (PROD_WIDTH + 1)'(1) << (GAIN_SHIFT - 1);

   typedef logic [31:0] phase_type;

   localparam phase_type HALF_TURN    = 32'h8000_0000;
   localparam phase_type QUARTER_TURN = 32'h4000_0000;
   localparam phase_type ANGLE_ROUND  = 32'h0000_8000;

   typedef struct packed {
      logic                          mode;
      logic signed [COORD_WIDTH-1:0] x_coord;
      logic signed [COORD_WIDTH-1:0] y_coord;
      logic signed [ANGLE_WIDTH-1:0] turn_angle;
   } req_type;

   typedef struct packed {
      logic signed [COORD_WIDTH-1:0] out_x;
      logic signed [COORD_WIDTH-1:0] out_y;
      logic        [COORD_WIDTH-1:0] magnitude;
      logic signed [ANGLE_WIDTH-1:0] direction;
      logic                          clipped;
   } rsp_type;

   function automatic phase_type atan_entry(input int idx);
      case (idx)
         0:       return 32'd536870912;
         1:       return 32'd316933406;
         2:       return 32'd167458907;
         3:       return 32'd85004756;
         4:       return 32'd42667331;
         5:       return 32'd21354465;
         6:       return 32'd10679838;
         7:       return 32'd5340245;
         8:       return 32'd2670163;
         9:       return 32'd1335087;
         10:      return 32'd667544;
         11:      return 32'd333772;
         12:      return 32'd166886;
         13:      return 32'd83443;
         14:      return 32'd41722;
         15:      return 32'd20861;
         16:      return 32'd10430;
         17:      return 32'd5215;
         18:      return 32'd2608;
         19:      return 32'd1304;
         20:      return 32'd652;
         21:      return 32'd326;
         22:      return 32'd163;
         23:      return 32'd81;
         default: return 32'd0;
      endcase
   endfunction

endpackage

// File: rtl/core/vector_rotate_and_polar.sv
// ----------------------------------------------------------------------------
// Vector rotate and polar: top level
// Pipelined CORDIC that optionally rotates a Q8.8 vector and then gives its
// magnitude and direction.
// ----------------------------------------------------------------------------
//
//   channel   ports                          beat accepted when
//   -------   ----------------------------   ------------------------------
//   request   start, busy, req_data          start high and busy low
//   response  rsp_valid, rsp_data            rsp_valid high (one cycle)
//
// A beat may enter on every cycle; each result passes through the two unrolled
// CORDIC chains and their three-stage gain correction. Reset is synchronous and
// clears only the valid bits; busy is high only while reset is held. The
// response side cannot stall, so the pipeline always advances.
//
module vector_rotate_and_polar import vrp_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_valid,
   output rsp_type rsp_data
);

   typedef struct packed {
      logic                          valid;
      logic                          mode;
      logic signed [COORD_WIDTH-1:0] x_orig;
      logic signed [COORD_WIDTH-1:0] y_orig;
      logic signed [DATA_WIDTH-1:0]  a;
      logic signed [DATA_WIDTH-1:0]  b;
      phase_type                     z;
   } rot_stage_type;

   typedef struct packed {
      logic                          valid;
      logic                          mode;
      logic signed [COORD_WIDTH-1:0] x_orig;
      logic signed [COORD_WIDTH-1:0] y_orig;
      logic                          neg_a;
      logic                          neg_b;
      logic        [DATA_WIDTH-1:0]  mag_a;
      logic        [DATA_WIDTH-1:0]  mag_b;
   } rot_abs_type;

   typedef struct packed {
      logic                          valid;
      logic                          mode;
      logic signed [COORD_WIDTH-1:0] x_orig;
      logic signed [COORD_WIDTH-1:0] y_orig;
      logic                          neg_a;
      logic                          neg_b;
      logic        [PROD_WIDTH-1:0]  prod_a;
      logic        [PROD_WIDTH-1:0]  prod_b;
   } rot_prod_type;

   typedef struct packed {
      logic                          valid;
      logic signed [COORD_WIDTH-1:0] x;
      logic signed [COORD_WIDTH-1:0] y;
      logic                          clipped;
   } sat_type;

   typedef struct packed {
      logic                          valid;
      logic                          zero;
      logic signed [COORD_WIDTH-1:0] x_res;
      logic signed [COORD_WIDTH-1:0] y_res;
      logic                          clipped;
      logic signed [DATA_WIDTH-1:0]  a;
      logic signed [DATA_WIDTH-1:0]  b;
      phase_type                     z;
   } vec_stage_type;

   typedef struct packed {
      logic                          valid;
      logic                          zero;
      logic signed [COORD_WIDTH-1:0] x_res;
      logic signed [COORD_WIDTH-1:0] y_res;
      logic                          clipped;
      logic                          neg;
      logic        [DATA_WIDTH-1:0]  mag;
      logic        [ANGLE_WIDTH-1:0] direction;
   } vec_abs_type;

   typedef struct packed {
      logic                          valid;
      logic                          zero;
      logic signed [COORD_WIDTH-1:0] x_res;
      logic signed [COORD_WIDTH-1:0] y_res;
      logic                          clipped;
      logic                          neg;
      logic        [PROD_WIDTH-1:0]  prod;
      logic        [ANGLE_WIDTH-1:0] direction;
   } vec_prod_type;

   function automatic logic [ROUND_WIDTH-1:0] round_gain(input logic [PROD_WIDTH-1:0] prod);
      logic [PROD_WIDTH:0] sum;
      sum = {1'b0, prod} + ROUND_HALF;
      return sum[PROD_WIDTH:GAIN_SHIFT];
   endfunction

   // Returns the clip flag above the saturated coordinate.
   function automatic logic [COORD_WIDTH:0] saturate(input logic neg,
                                                     input logic [ROUND_WIDTH-1:0] mag);
      logic signed [ROUND_WIDTH:0] value;
      logic                        in_range;
      value    = neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
      in_range = (value[ROUND_WIDTH:COORD_WIDTH-1] ==
                  {(ROUND_WIDTH - COORD_WIDTH + 2){value[ROUND_WIDTH]}});
      if (in_range) begin
         return {1'b0, value[COORD_WIDTH-1:0]};
      end
      return {1'b1, value[ROUND_WIDTH], {(COORD_WIDTH - 1){~value[ROUND_WIDTH]}}};
   endfunction

   rot_stage_type rot_in [STAGES+1];
   rot_stage_type rot_ff [STAGES+1];
   rot_abs_type   rabs_in, rabs_ff;
   rot_prod_type  rprod_in, rprod_ff;
   sat_type       sat_in, sat_ff;
   vec_stage_type vec_in [STAGES+1];
   vec_stage_type vec_ff [STAGES+1];
   vec_abs_type   vabs_in, vabs_ff;
   vec_prod_type  vprod_in, vprod_ff;
   rsp_type       rsp_in, rsp_ff;
   logic          rsp_valid_in, rsp_valid_ff;

   assign busy = reset;

   // Rotation entry: fold turns beyond a quarter turn by negating the vector.
   always_comb begin
      logic signed [DATA_WIDTH-1:0] x_scaled;
      logic signed [DATA_WIDTH-1:0] y_scaled;
      phase_type                    turn_phase;
      phase_type                    turn_test;
      x_scaled   = DATA_WIDTH'($signed(req_data.x_coord)) <<< GUARD;
      y_scaled   = DATA_WIDTH'($signed(req_data.y_coord)) <<< GUARD;
      turn_phase = {req_data.turn_angle, 16'h0000};
      turn_test  = turn_phase + QUARTER_TURN;
      rot_in[0].valid  = start && !busy;
      rot_in[0].mode   = req_data.mode;
      rot_in[0].x_orig = req_data.x_coord;
      rot_in[0].y_orig = req_data.y_coord;
      if (turn_test[31]) begin
         rot_in[0].a = -x_scaled;
         rot_in[0].b = -y_scaled;
         rot_in[0].z = turn_phase ^ HALF_TURN;
      end else begin
         rot_in[0].a = x_scaled;
         rot_in[0].b = y_scaled;
         rot_in[0].z = turn_phase;
      end
   end

   for (genvar i = 0; i < STAGES; i++) begin : g_rot
      logic signed [DATA_WIDTH-1:0] a_shift, b_shift;
      assign a_shift = $signed(rot_ff[i].a) >>> i;
      assign b_shift = $signed(rot_ff[i].b) >>> i;
      always_comb begin
         rot_in[i+1] = rot_ff[i];
         if (!rot_ff[i].z[31]) begin
            rot_in[i+1].a = $signed(rot_ff[i].a) - b_shift;
            rot_in[i+1].b = $signed(rot_ff[i].b) + a_shift;
            rot_in[i+1].z = rot_ff[i].z - atan_entry(i);
         end else begin
            rot_in[i+1].a = $signed(rot_ff[i].a) + b_shift;
            rot_in[i+1].b = $signed(rot_ff[i].b) - a_shift;
            rot_in[i+1].z = rot_ff[i].z + atan_entry(i);
         end
      end
   end

   always_comb begin
      rabs_in.valid  = rot_ff[STAGES].valid;
      rabs_in.mode   = rot_ff[STAGES].mode;
      rabs_in.x_orig = rot_ff[STAGES].x_orig;
      rabs_in.y_orig = rot_ff[STAGES].y_orig;
      rabs_in.neg_a  = rot_ff[STAGES].a[DATA_WIDTH-1];
      rabs_in.neg_b  = rot_ff[STAGES].b[DATA_WIDTH-1];
      rabs_in.mag_a  = rabs_in.neg_a ? $unsigned(-rot_ff[STAGES].a)
                                     : $unsigned(rot_ff[STAGES].a);
      rabs_in.mag_b  = rabs_in.neg_b ? $unsigned(-rot_ff[STAGES].b)
                                     : $unsigned(rot_ff[STAGES].b);
   end

   always_comb begin
      rprod_in.valid  = rabs_ff.valid;
      rprod_in.mode   = rabs_ff.mode;
      rprod_in.x_orig = rabs_ff.x_orig;
      rprod_in.y_orig = rabs_ff.y_orig;
      rprod_in.neg_a  = rabs_ff.neg_a;
      rprod_in.neg_b  = rabs_ff.neg_b;
      rprod_in.prod_a = PROD_WIDTH'(rabs_ff.mag_a) * PROD_WIDTH'(INV_GAIN);
      rprod_in.prod_b = PROD_WIDTH'(rabs_ff.mag_b) * PROD_WIDTH'(INV_GAIN);
   end

   always_comb begin
      logic [COORD_WIDTH:0] x_sat;
      logic [COORD_WIDTH:0] y_sat;
      x_sat = saturate(rprod_ff.neg_a, round_gain(rprod_ff.prod_a));
      y_sat = saturate(rprod_ff.neg_b, round_gain(rprod_ff.prod_b));
      sat_in.valid = rprod_ff.valid;
      if (rprod_ff.mode) begin
         sat_in.x       = x_sat[COORD_WIDTH-1:0];
         sat_in.y       = y_sat[COORD_WIDTH-1:0];
         sat_in.clipped = x_sat[COORD_WIDTH] || y_sat[COORD_WIDTH];
      end else begin
         sat_in.x       = rprod_ff.x_orig;
         sat_in.y       = rprod_ff.y_orig;
         sat_in.clipped = 1'b0;
      end
   end

   // Vectoring entry: vectors in the left half plane are turned by pi first.
   always_comb begin
      logic signed [DATA_WIDTH-1:0] x_scaled;
      logic signed [DATA_WIDTH-1:0] y_scaled;
      x_scaled = DATA_WIDTH'($signed(sat_ff.x)) <<< GUARD;
      y_scaled = DATA_WIDTH'($signed(sat_ff.y)) <<< GUARD;
      vec_in[0].valid   = sat_ff.valid;
      vec_in[0].zero    = (sat_ff.x == '0) && (sat_ff.y == '0);
      vec_in[0].x_res   = sat_ff.x;
      vec_in[0].y_res   = sat_ff.y;
      vec_in[0].clipped = sat_ff.clipped;
      if (sat_ff.x[COORD_WIDTH-1]) begin
         vec_in[0].a = -x_scaled;
         vec_in[0].b = -y_scaled;
         vec_in[0].z = HALF_TURN;
      end else begin
         vec_in[0].a = x_scaled;
         vec_in[0].b = y_scaled;
         vec_in[0].z = '0;
      end
   end

   for (genvar i = 0; i < STAGES; i++) begin : g_vec
      logic signed [DATA_WIDTH-1:0] a_shift, b_shift;
      assign a_shift = $signed(vec_ff[i].a) >>> i;
      assign b_shift = $signed(vec_ff[i].b) >>> i;
      always_comb begin
         vec_in[i+1] = vec_ff[i];
         if (!vec_ff[i].b[DATA_WIDTH-1]) begin
            vec_in[i+1].a = $signed(vec_ff[i].a) + b_shift;
            vec_in[i+1].b = $signed(vec_ff[i].b) - a_shift;
            vec_in[i+1].z = vec_ff[i].z + atan_entry(i);
         end else begin
            vec_in[i+1].a = $signed(vec_ff[i].a) - b_shift;
            vec_in[i+1].b = $signed(vec_ff[i].b) + a_shift;
            vec_in[i+1].z = vec_ff[i].z - atan_entry(i);
         end
      end
   end

   always_comb begin
      phase_type dir_sum;
      dir_sum = vec_ff[STAGES].z + ANGLE_ROUND;
      vabs_in.valid     = vec_ff[STAGES].valid;
      vabs_in.zero      = vec_ff[STAGES].zero;
      vabs_in.x_res     = vec_ff[STAGES].x_res;
      vabs_in.y_res     = vec_ff[STAGES].y_res;
      vabs_in.clipped   = vec_ff[STAGES].clipped;
      vabs_in.neg       = vec_ff[STAGES].a[DATA_WIDTH-1];
      vabs_in.mag       = vabs_in.neg ? $unsigned(-vec_ff[STAGES].a)
                                      : $unsigned(vec_ff[STAGES].a);
      vabs_in.direction = dir_sum[31:32-ANGLE_WIDTH];
   end

   always_comb begin
      vprod_in.valid     = vabs_ff.valid;
      vprod_in.zero      = vabs_ff.zero;
      vprod_in.x_res     = vabs_ff.x_res;
      vprod_in.y_res     = vabs_ff.y_res;
      vprod_in.clipped   = vabs_ff.clipped;
      vprod_in.neg       = vabs_ff.neg;
      vprod_in.prod      = PROD_WIDTH'(vabs_ff.mag) * PROD_WIDTH'(INV_GAIN);
      vprod_in.direction = vabs_ff.direction;
   end

   always_comb begin
      logic [ROUND_WIDTH-1:0] mag_round;
      mag_round        = round_gain(vprod_ff.prod);
      rsp_valid_in     = vprod_ff.valid;
      rsp_in.out_x     = vprod_ff.x_res;
      rsp_in.out_y     = vprod_ff.y_res;
      rsp_in.clipped   = vprod_ff.clipped;
      if (vprod_ff.zero || vprod_ff.neg) begin
         rsp_in.magnitude = '0;
      end else if (mag_round[ROUND_WIDTH-1:COORD_WIDTH] != '0) begin
         rsp_in.magnitude = '1;
      end else begin
         rsp_in.magnitude = mag_round[COORD_WIDTH-1:0];
      end
      rsp_in.direction = vprod_ff.zero ? '0 : vprod_ff.direction;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= STAGES; k++) begin
            rot_ff[k].valid <= 1'b0;
            vec_ff[k].valid <= 1'b0;
         end
         rabs_ff.valid  <= 1'b0;
         rprod_ff.valid <= 1'b0;
         sat_ff.valid   <= 1'b0;
         vabs_ff.valid  <= 1'b0;
         vprod_ff.valid <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         rot_ff   <= rot_in;
         rabs_ff  <= rabs_in;
         rprod_ff <= rprod_in;
         sat_ff   <= sat_in;
         vec_ff   <= vec_in;
         vabs_ff  <= vabs_in;
         vprod_ff <= vprod_in;
         rsp_ff   <= rsp_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// File: rtl/core/vrp_checker.sv
// ----------------------------------------------------------------------------
// Vector rotate and polar: port checker
// Watches the top-level ports for latency, pass-through and result sanity.
// ----------------------------------------------------------------------------
`include "vector_rotate_and_polar_macros.svh"

module vrp_checker import vrp_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    start,
   input logic    busy,
   input req_type req_data,
   input logic    rsp_valid,
   input rsp_type rsp_data
);

   localparam int SETTLE_WIDTH = $clog2(LATENCY + 1);
   localparam logic signed [COORD_WIDTH-1:0] COORD_MAX = {1'b0, {(COORD_WIDTH - 1){1'b1}}};
   localparam logic signed [COORD_WIDTH-1:0] COORD_MIN = {1'b1, {(COORD_WIDTH - 1){1'b0}}};

   logic [SETTLE_WIDTH-1:0] settle_in, settle_ff;
   logic                    settled;

   // The pipeline history is known only once a full latency has passed reset.
   assign settled   = (settle_ff == SETTLE_WIDTH'(LATENCY));
   assign settle_in = settled ? settle_ff : settle_ff + SETTLE_WIDTH'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         settle_ff <= '0;
      end else begin
         settle_ff <= settle_in;
      end
   end

   `VRP_ASSERT_IMPLY(a_beat_latency, settled,
                     rsp_valid == $past(start && !busy, LATENCY),
                     "response beat does not match request beat")
   `VRP_ASSERT_IMPLY(a_polar_pass, settled && rsp_valid && !$past(req_data.mode, LATENCY),
                     (rsp_data.out_x == $past(req_data.x_coord, LATENCY)) &&
                     (rsp_data.out_y == $past(req_data.y_coord, LATENCY)) &&
                     !rsp_data.clipped,
                     "polar beat altered its coordinates")
   `VRP_ASSERT_IMPLY(a_zero_vector,
                     rsp_valid && (rsp_data.out_x == '0) && (rsp_data.out_y == '0),
                     (rsp_data.magnitude == '0) && (rsp_data.direction == '0),
                     "zero vector gave nonzero polar form")
   `VRP_ASSERT_IMPLY(a_clip_rail, rsp_valid && rsp_data.clipped,
                     (rsp_data.out_x == COORD_MAX) || (rsp_data.out_x == COORD_MIN) ||
                     (rsp_data.out_y == COORD_MAX) || (rsp_data.out_y == COORD_MIN),
                     "clip flag without a saturated coordinate")

endmodule

bind vector_rotate_and_polar vrp_checker u_vrp_checker (.*);

// File: sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Vector rotate and polar: testbench
// Sends directed and random vectors through the CORDIC pipeline with random
// gaps, predicts the results of all but the first three directed rows with an
// integer CORDIC of its own, and checks each response beat field by field in order.
// ----------------------------------------------------------------------------
module tb;
   import vrp_pkg::*;

   localparam int  CYCLE_LIMIT  = 200000;
   localparam int  RANDOM_BEATS = 1400;
   localparam int  PASSES       = (CORDIC_STAGES < 24) ? CORDIC_STAGES : 24;
   localparam longint GAIN_RECIP = 64'sd10188014;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   logic    busy;
   req_type req_data = '0;
   logic    rsp_valid;
   rsp_type rsp_data;

   rsp_type pending_polar [$];
   req_type row_stim [$];
   bit      row_typed [$];
   rsp_type row_want [$];
   int      error_count = 0;
   int      cycle_count = 0;

   bit [31:0] arctan_lut [24] = '{
      32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
      32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
      32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
      32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163, 32'd81
   };

   vector_rotate_and_polar u_dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   always #5 clock = ~clock;

   function automatic longint unscale(input longint v);
      longint half;
      half = 64'sd1 <<< 29;
      if (v >= 0) begin
         return (v * GAIN_RECIP + half) >>> 30;
      end
      return -(((-v) * GAIN_RECIP + half) >>> 30);
   endfunction

   function automatic rsp_type cordic_predict(input req_type r);
      longint    xv, yv, a, b, da, db, m;
      bit [31:0] z, zr;
      bit        hit;
      rsp_type   res;
      xv  = $signed(r.x_coord);
      yv  = $signed(r.y_coord);
      hit = 1'b0;
      if (r.mode) begin
         a = xv * 64;
         b = yv * 64;
         z = {r.turn_angle, 16'h0000};
         if (z + 32'h4000_0000 >= 32'h8000_0000) begin
            a = -a;
            b = -b;
            z = z + 32'h8000_0000;
         end
         for (int i = 0; i < PASSES; i++) begin
            da = b >>> i;
            db = a >>> i;
            if (!z[31]) begin
               a = a - da;
               b = b + db;
               z = z - arctan_lut[i];
            end else begin
               a = a + da;
               b = b - db;
               z = z + arctan_lut[i];
            end
         end
         xv = unscale(a);
         yv = unscale(b);
         if (xv > 32767) begin
            xv  = 32767;
            hit = 1'b1;
         end else if (xv < -32768) begin
            xv  = -32768;
            hit = 1'b1;
         end
         if (yv > 32767) begin
            yv  = 32767;
            hit = 1'b1;
         end else if (yv < -32768) begin
            yv  = -32768;
            hit = 1'b1;
         end
      end
      res.out_x   = xv[15:0];
      res.out_y   = yv[15:0];
      res.clipped = hit;
      if (xv == 0 && yv == 0) begin
         res.magnitude = '0;
         res.direction = '0;
      end else begin
         a = xv * 64;
         b = yv * 64;
         z = 32'h0;
         if (a < 0) begin
            a = -a;
            b = -b;
            z = 32'h8000_0000;
         end
         for (int i = 0; i < PASSES; i++) begin
            da = b >>> i;
            db = a >>> i;
            if (b >= 0) begin
               a = a + da;
               b = b - db;
               z = z + arctan_lut[i];
            end else begin
               a = a - da;
               b = b + db;
               z = z - arctan_lut[i];
            end
         end
         m = unscale(a);
         if (m < 0) begin
            m = 0;
         end
         if (m > 65535) begin
            m = 65535;
         end
         res.magnitude = m[15:0];
         zr            = z + 32'h0000_8000;
         res.direction = zr[31:16];
      end
      return res;
   endfunction

   function automatic logic [15:0] draw_coord();
      int pick, v;
      pick = $urandom_range(0, 9);
      if (pick < 5) begin
         return 16'($urandom);
      end
      if (pick < 8) begin
         v = $urandom_range(0, 2047) - 1024;
         return v[15:0];
      end
      case ($urandom_range(0, 4))
         0:       return 16'h7FFF;
         1:       return 16'h8000;
         2:       return 16'h0000;
         3:       return 16'h0001;
         default: return 16'hFFFF;
      endcase
   endfunction

   function automatic logic [15:0] draw_turn();
      if ($urandom_range(0, 7) < 6) begin
         return 16'($urandom);
      end
      case ($urandom_range(0, 6))
         0:       return 16'h0000;
         1:       return 16'h4000;
         2:       return 16'hC000;
         3:       return 16'h3FFF;
         4:       return 16'hBFFF;
         5:       return 16'h8000;
         default: return 16'h7FFF;
      endcase
   endfunction

   task automatic add_row(input bit m, input int x, input int y, input int t,
                          input bit typed = 1'b0, input rsp_type want = '0);
      req_type r;
      r.mode       = m;
      r.x_coord    = x[15:0];
      r.y_coord    = y[15:0];
      r.turn_angle = t[15:0];
      row_stim.push_back(r);
      row_typed.push_back(typed);
      row_want.push_back(want);
   endtask

   // The expectation is queued at the edge that accepts the beat.
   task automatic drive_beat(input req_type item, input bit typed, input rsp_type want,
                             input bit lively);
      int gap;
      gap = lively ? $urandom_range(0, 11) : 0;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_data <= item;
      start    <= 1'b1;
      @(posedge clock);
      while (busy !== 1'b0) @(posedge clock);
      pending_polar.push_back(typed ? want : cordic_predict(item));
   endtask

   task automatic report_field(input string field, input logic [15:0] want,
                               input logic [15:0] got);
      error_count++;
      $display("%0t mismatch %s: expected %h, actual %h", $time, field, want, got);
   endtask

   always @(posedge clock) begin
      rsp_type want, got;
      if (!reset && rsp_valid === 1'b1) begin
         got = rsp_data;
         if (pending_polar.size() == 0) begin
            error_count++;
            $display("%0t unexpected beat: expected none, actual %h", $time, got);
         end else begin
            want = pending_polar.pop_front();
            if (got.out_x !== want.out_x) report_field("out_x", want.out_x, got.out_x);
            if (got.out_y !== want.out_y) report_field("out_y", want.out_y, got.out_y);
            if (got.magnitude !== want.magnitude) begin
               report_field("magnitude", want.magnitude, got.magnitude);
            end
            if (got.direction !== want.direction) begin
               report_field("direction", want.direction, got.direction);
            end
            if (got.clipped !== want.clipped) begin
               report_field("clipped", {15'b0, want.clipped}, {15'b0, got.clipped});
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb NOT OK");
         $finish;
      end
   end

   initial begin
      req_type item;
      bit      lively;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      add_row(1'b0, 0, 0, 0, 1'b1, '0);
      add_row(1'b1, 0, 0, 16384, 1'b1, '0);
      add_row(1'b1, 0, 0, -32768, 1'b1, '0);
      add_row(1'b0, 32767, 0, 0);
      add_row(1'b0, -32768, 0, 0);
      add_row(1'b0, 0, 32767, 0);
      add_row(1'b0, 0, -32768, 0);
      add_row(1'b0, 32767, 32767, 0);
      add_row(1'b0, -32768, -32768, 0);
      add_row(1'b0, -32768, 32767, 0);
      add_row(1'b0, -1, 0, 0);
      add_row(1'b0, 1, 1, 0);
      add_row(1'b0, -256, 0, 12345);
      add_row(1'b1, 32767, 32767, 8192);
      add_row(1'b1, -32768, -32768, -8192);
      add_row(1'b1, 256, 0, 16384);
      add_row(1'b1, 256, 0, 16383);
      add_row(1'b1, 256, 0, -16384);
      add_row(1'b1, 256, 0, -16385);
      add_row(1'b1, 256, 0, 32767);
      add_row(1'b1, 256, 0, -32768);
      add_row(1'b1, 32767, -32768, 32767);
      add_row(1'b1, 0, -32768, 0);

      for (int i = 0; i < row_stim.size(); i++) begin
         drive_beat(row_stim[i], row_typed[i], row_want[i], 1'b1);
      end

      lively = 1'b1;
      for (int i = 0; i < RANDOM_BEATS; i++) begin
         if (i % 64 == 0) begin
            lively = ($urandom_range(0, 3) != 0);
         end
         item.mode       = 1'($urandom_range(0, 1));
         item.x_coord    = draw_coord();
         item.y_coord    = draw_coord();
         item.turn_angle = draw_turn();
         drive_beat(item, 1'b0, '0, lively);
      end
      start <= 1'b0;

      while (pending_polar.size() != 0) @(posedge clock);
      repeat (LATENCY + 8) @(posedge clock);
      if (error_count == 0) begin
         $display("tb OK");
      end else begin
         $display("tb NOT OK");
      end
      $finish;
   end

endmodule
